@@ rtl/pfla_pkg.sv @@
// Shared constants, command codes and helper types for the power-of-two free-list allocator.
package pfla_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int SLOTS = 2048;
    localparam int MAX_REGION_BYTES = 65536;
    localparam int CLS_W = $clog2(MAX_CLASSES);
    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOTS);
    localparam logic [16:0] MIN_REGION = 17'd512;
    localparam logic [6:0] HEADER_SLACK = 7'd4;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_DESTROY = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [1:0] REG_REGION  = 2'd0;
    localparam logic [1:0] REG_HEADER  = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;
    localparam logic [1:0] REG_POINTER = 2'd3;

    // Saturating add and subtract requests towards the used-byte counter.
    typedef struct packed {
        logic        add;
        logic        sub;
        logic [32:0] amount;
    } used_req_t;

endpackage

@@ rtl/pfla_used.sv @@
// Saturating used-byte counter, one add or subtract per cycle.
module pfla_used
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfla_pkg::used_req_t  req,
    output logic [31:0]          used_bytes
);

    logic [31:0] used_reg;
    logic [31:0] used_next;
    logic [33:0] sum;

    always_comb
    begin
        sum = {2'b00, used_reg} + {1'b0, req.amount};
        used_next = used_reg;
        if (req.add)
        begin
            used_next = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
        end
        else if (req.sub)
        begin
            used_next = (req.amount >= {1'b0, used_reg}) ? 32'd0
                        : used_reg - req.amount[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign used_bytes = used_reg;

endmodule

@@ rtl/pow2_free_list_allocator_core.sv @@
// Top level of the power-of-two free-list allocator: sequencer, lists and slot memories.
//
//  channel   | signals                                           | handshake
//  ----------+---------------------------------------------------+-------------------------
//  command   | start, busy, mode, request_bytes, block_address   | start && !busy
//  result    | done, status, address, used_bytes, class_count    | done strobe, one cycle
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data         | cfg_valid && cfg_ready
//
// Each command word runs through a small sequencer around one shared shifter and
// a pair of slot memories with one write port and one registered read port. Init
// counts the classes that fit, places the origin, clears the lists and carves the
// region; alloc doubles the size, steps the class index, scans the classes, pops a
// block and pushes the upper half of each split; free checks the address, reads the
// recorded class and pushes the block; destroy clears the lists. As the read port is
// registered, a read step comes before each pop and each class check.
// Reset clears the list heads, class count, origin and used counter; the slot memories
// are left undefined. The result receiver cannot stall: done lasts one cycle.
module pow2_free_list_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] address,
    output logic [31:0] used_bytes,
    output logic [4:0]  class_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CLS_W  = pfla_pkg::CLS_W;
    localparam int CNT_W  = pfla_pkg::CNT_W;
    localparam int SLOT_W = pfla_pkg::SLOT_W;
    localparam int LINK_W = pfla_pkg::LINK_W;

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MB       = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_I_COUNT  = 5'd3;
    localparam logic [4:0] S_I_ORG    = 5'd4;
    localparam logic [4:0] S_I_CLR    = 5'd5;
    localparam logic [4:0] S_I_CARVE  = 5'd6;
    localparam logic [4:0] S_I_SLOT   = 5'd7;
    localparam logic [4:0] S_I_WRITE  = 5'd8;
    localparam logic [4:0] S_I_END    = 5'd9;
    localparam logic [4:0] S_A_SIZE   = 5'd10;
    localparam logic [4:0] S_A_IDX    = 5'd11;
    localparam logic [4:0] S_A_SCAN   = 5'd12;
    localparam logic [4:0] S_A_READ   = 5'd13;
    localparam logic [4:0] S_A_POP    = 5'd14;
    localparam logic [4:0] S_A_SPLIT  = 5'd15;
    localparam logic [4:0] S_A_PUSH   = 5'd16;
    localparam logic [4:0] S_A_FIN    = 5'd17;
    localparam logic [4:0] S_A_ADDR   = 5'd18;
    localparam logic [4:0] S_F_CHK    = 5'd19;
    localparam logic [4:0] S_F_READ   = 5'd20;
    localparam logic [4:0] S_F_CLS    = 5'd21;
    localparam logic [4:0] S_F_PUSH   = 5'd22;
    localparam logic [4:0] S_REPLY    = 5'd23;

    logic [4:0]  state_reg, state_next;

    // Configuration registers.
    logic [16:0] region_reg;
    logic [5:0]  header_reg;
    logic [7:0]  control_reg;
    logic [3:0]  pointer_reg;

    // Allocator state.
    logic [LINK_W-1:0] head_reg [pfla_pkg::MAX_CLASSES];
    logic [CNT_W-1:0]  active_reg;
    logic [15:0]       origin_reg;

    // Slot memories (undefined until written).
    logic [LINK_W-1:0] slot_next_mem  [pfla_pkg::SLOTS];
    logic [CLS_W-1:0]  slot_class_mem [pfla_pkg::SLOTS];
    logic [LINK_W-1:0] rd_next_reg;
    logic [CLS_W-1:0]  rd_class_reg;

    // Working registers.
    logic [1:0]        mode_reg;
    logic [15:0]       req_reg;
    logic [15:0]       blk_reg;
    logic [4:0]        mb_log_reg;     // log2 of the minimum block
    logic [17:0]       sz_reg;         // rounded alloc size, or carve remains
    logic [CNT_W-1:0]  k_reg;          // class counter
    logic [CNT_W-1:0]  idx_reg;        // requested class
    logic [17:0]       cur_reg;        // carve offset from origin
    logic [17:0]       org_reg;        // full-width origin during init
    logic [SLOT_W:0]   s_reg;          // slot being worked on
    logic [1:0]        status_reg;
    logic [15:0]       addr_reg;
    logic              done_reg;
    logic [CLS_W-1:0]  cls_reg;

    // Memory write port, driven by the sequencer.
    logic              we;
    logic [SLOT_W-1:0] w_slot;
    logic [LINK_W-1:0] w_next;
    logic [CLS_W-1:0]  w_class;
    logic              wr_next_en;
    logic [SLOT_W-1:0] r_slot;

    pfla_pkg::used_req_t used_req;

    // The shared shifter: minimum block shifted by a class number.
    logic [CNT_W-1:0]  sh_amt;
    logic [33:0]       sh_out;
    assign sh_out = 34'd1 << (mb_log_reg + 5'(sh_amt));

    logic [6:0] need;
    assign need = {1'b0, header_reg} + pfla_pkg::HEADER_SLACK;

    // Minimum block exponent: smallest p >= 1 with 2^p >= header + 4.
    logic [4:0] mb_log_c;
    always_comb
    begin
        mb_log_c = 5'd7;
        for (int p = 7; p >= 1; p--)
        begin
            if ((8'd1 << p) >= {1'b0, need})
            begin
                mb_log_c = 5'(p);
            end
        end
    end

    // Free address check terms.
    logic [16:0] free_base;
    logic [16:0] free_off;
    assign free_base = {1'b0, origin_reg} + {11'd0, header_reg};
    assign free_off  = {1'b0, blk_reg} - free_base;

    logic [16:0] free_mask;
    assign free_mask = (17'd1 << mb_log_reg) - 17'd1;

    logic [16:0] free_slot;
    assign free_slot = free_off >> mb_log_reg;

    logic [CLS_W-1:0] k_cls;
    assign k_cls = k_reg[CLS_W-1:0];

    // Upper half of a split block; it may lie beyond the last slot.
    logic [16:0] split_slot;
    assign split_slot = {5'd0, s_reg} + (17'd1 << k_reg);

    always_comb
    begin
        sh_amt = k_reg;
        if (state_reg == S_A_IDX)
        begin
            sh_amt = idx_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_MB;
            S_MB:       state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (mode_reg)
                    pfla_pkg::MODE_INIT:    state_next = S_I_COUNT;
                    pfla_pkg::MODE_ALLOC:   state_next = S_A_SIZE;
                    pfla_pkg::MODE_FREE:    state_next = S_F_CHK;
                    default:                state_next = S_REPLY;
                endcase
            end
            default:    state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_class_mem[w_slot] <= w_class;
            if (wr_next_en)
            begin
                slot_next_mem[w_slot] <= w_next;
            end
        end
        rd_next_reg  <= slot_next_mem[r_slot];
        rd_class_reg <= slot_class_mem[r_slot];
    end

    always_comb
    begin
        r_slot = s_reg[SLOT_W-1:0];
        if (state_reg == S_F_CHK)
        begin
            r_slot = free_slot[SLOT_W-1:0];
        end
    end

    // Main sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            region_reg  <= 17'd4096;
            header_reg  <= 6'd16;
            control_reg <= 8'd40;
            pointer_reg <= 4'd8;
            for (int i = 0; i < pfla_pkg::MAX_CLASSES; i++)
            begin
                head_reg[i] <= pfla_pkg::NO_SLOT;
            end
            active_reg  <= '0;
            origin_reg  <= '0;
            done_reg    <= 1'b0;
            status_reg  <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfla_pkg::REG_REGION:  region_reg  <= cfg_data[16:0];
                    pfla_pkg::REG_HEADER:  header_reg  <= cfg_data[5:0];
                    pfla_pkg::REG_CONTROL: control_reg <= cfg_data[7:0];
                    default:               pointer_reg <= cfg_data[3:0];
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        req_reg  <= request_bytes;
                        blk_reg  <= block_address;
                        state_reg <= S_MB;
                    end
                end
                S_MB:
                begin
                    mb_log_reg <= mb_log_c;
                    status_reg <= pfla_pkg::ST_DONE;
                    addr_reg   <= '0;
                    k_reg      <= '0;
                    state_reg  <= state_next;
                end
                S_DISPATCH:
                begin
                    state_reg <= state_next;
                    if (mode_reg == pfla_pkg::MODE_INIT)
                    begin
                        if (region_reg < pfla_pkg::MIN_REGION
                            || region_reg > 17'(pfla_pkg::MAX_REGION_BYTES))
                        begin
                            status_reg <= pfla_pkg::ST_REJECTED;
                            state_reg  <= S_REPLY;
                        end
                    end
                    else if (mode_reg == pfla_pkg::MODE_ALLOC
                             || mode_reg == pfla_pkg::MODE_FREE)
                    begin
                        if (active_reg == '0)
                        begin
                            status_reg <= pfla_pkg::ST_REJECTED;
                            state_reg  <= S_REPLY;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < pfla_pkg::MAX_CLASSES; i++)
                        begin
                            head_reg[i] <= pfla_pkg::NO_SLOT;
                        end
                        active_reg <= '0;
                    end
                    sz_reg <= 18'd2;
                end
                // Init: count classes whose block fits in the region.
                S_I_COUNT:
                begin
                    if (k_reg < CNT_W'(pfla_pkg::MAX_CLASSES)
                        && sh_out <= {17'd0, region_reg})
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_I_ORG;
                    end
                end
                S_I_ORG:
                begin
                    org_reg <= {10'd0, control_reg} + 18'(k_reg) * {14'd0, pointer_reg};
                    state_reg <= S_I_CLR;
                end
                S_I_CLR:
                begin
                    for (int i = 0; i < pfla_pkg::MAX_CLASSES; i++)
                    begin
                        head_reg[i] <= pfla_pkg::NO_SLOT;
                    end
                    active_reg <= k_reg;
                    origin_reg <= org_reg[15:0];
                    cur_reg    <= '0;
                    sz_reg     <= (org_reg < {1'b0, region_reg})
                                  ? {1'b0, region_reg} - org_reg : 18'd0;
                    state_reg  <= S_I_CARVE;
                end
                S_I_CARVE:
                begin
                    // k_reg counts down; the class tested is k_reg - 1.
                    if (k_reg == '0 || sz_reg < (18'd1 << mb_log_reg))
                    begin
                        state_reg <= S_I_END;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_I_SLOT;
                    end
                end
                S_I_SLOT:
                begin
                    if (sh_out <= {16'd0, sz_reg})
                    begin
                        s_reg <= (SLOT_W+1)'(cur_reg >> mb_log_reg);
                        if ((cur_reg >> mb_log_reg) < 18'(pfla_pkg::SLOTS))
                        begin
                            state_reg <= S_I_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_I_CARVE;
                        end
                        cur_reg <= cur_reg + sh_out[17:0];
                        sz_reg  <= sz_reg - sh_out[17:0];
                    end
                    else
                    begin
                        state_reg <= S_I_CARVE;
                    end
                end
                S_I_WRITE:
                begin
                    head_reg[k_cls] <= {1'b0, s_reg[SLOT_W-1:0]};
                    state_reg <= S_I_CARVE;
                end
                S_I_END:
                begin
                    state_reg <= S_REPLY;
                end
                // Alloc: round request plus header up to a power of two, no smaller than the minimum block.
                S_A_SIZE:
                begin
                    if ({16'd0, sz_reg} < 34'(req_reg) + 34'(header_reg))
                    begin
                        sz_reg <= sz_reg << 1;
                    end
                    else
                    begin
                        if (sz_reg < (18'd1 << mb_log_reg))
                        begin
                            sz_reg <= 18'd1 << mb_log_reg;
                        end
                        idx_reg <= '0;
                        state_reg <= S_A_IDX;
                    end
                end
                S_A_IDX:
                begin
                    if (idx_reg < CNT_W'(pfla_pkg::MAX_CLASSES)
                        && sh_out < {16'd0, sz_reg})
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (idx_reg >= active_reg)
                    begin
                        status_reg <= pfla_pkg::ST_NO_MEM;
                        state_reg  <= S_REPLY;
                    end
                    else
                    begin
                        k_reg <= idx_reg;
                        state_reg <= S_A_SCAN;
                    end
                end
                S_A_SCAN:
                begin
                    if (k_reg >= active_reg)
                    begin
                        status_reg <= pfla_pkg::ST_NO_MEM;
                        state_reg  <= S_REPLY;
                    end
                    else if (head_reg[k_cls] >= pfla_pkg::NO_SLOT)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        s_reg <= head_reg[k_cls][SLOT_W:0];
                        state_reg <= S_A_READ;
                    end
                end
                S_A_READ:
                begin
                    state_reg <= S_A_POP;
                end
                S_A_POP:
                begin
                    head_reg[k_cls] <= (rd_next_reg < pfla_pkg::NO_SLOT)
                                       ? rd_next_reg : pfla_pkg::NO_SLOT;
                    state_reg <= S_A_SPLIT;
                end
                S_A_SPLIT:
                begin
                    if (k_reg > idx_reg)
                    begin
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_A_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_A_FIN;
                    end
                end
                S_A_PUSH:
                begin
                    // Upper half at slot s + 2^k.
                    if (split_slot < 17'(pfla_pkg::SLOTS))
                    begin
                        head_reg[k_cls] <= LINK_W'(split_slot);
                    end
                    state_reg <= S_A_SPLIT;
                end
                S_A_FIN:
                begin
                    state_reg <= S_A_ADDR;
                end
                S_A_ADDR:
                begin
                    addr_reg <= 16'(32'(origin_reg)
                                + (32'(s_reg) << mb_log_reg) + 32'(header_reg));
                    state_reg <= S_REPLY;
                end
                // Free: validate the address, then read the recorded class.
                S_F_CHK:
                begin
                    if (blk_reg == '0 || {1'b0, blk_reg} < free_base
                        || (free_off & free_mask) != '0
                        || free_slot >= 17'(pfla_pkg::SLOTS))
                    begin
                        status_reg <= pfla_pkg::ST_REJECTED;
                        state_reg  <= S_REPLY;
                    end
                    else
                    begin
                        s_reg <= free_slot[SLOT_W:0];
                        state_reg <= S_F_READ;
                    end
                end
                S_F_READ:
                begin
                    state_reg <= S_F_CLS;
                end
                S_F_CLS:
                begin
                    if (CNT_W'(rd_class_reg) >= active_reg)
                    begin
                        status_reg <= pfla_pkg::ST_REJECTED;
                        state_reg  <= S_REPLY;
                    end
                    else
                    begin
                        cls_reg <= rd_class_reg;
                        k_reg   <= CNT_W'(rd_class_reg);
                        state_reg <= S_F_PUSH;
                    end
                end
                S_F_PUSH:
                begin
                    head_reg[cls_reg] <= {1'b0, s_reg[SLOT_W-1:0]};
                    state_reg <= S_REPLY;
                end
                S_REPLY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Memory writes and used-counter requests.
    always_comb
    begin
        we         = 1'b0;
        wr_next_en = 1'b1;
        w_slot     = s_reg[SLOT_W-1:0];
        w_next     = pfla_pkg::NO_SLOT;
        w_class    = k_cls;
        used_req   = '0;
        case (state_reg)
            S_I_WRITE:
            begin
                we = 1'b1;
                used_req.add = 1'b1;
                used_req.amount = 33'(header_reg);
            end
            S_I_END:
            begin
                used_req.add = 1'b1;
                used_req.amount = 33'(org_reg);
            end
            S_A_PUSH:
            begin
                w_slot = SLOT_W'(split_slot);
                w_next = head_reg[k_cls];
                if (split_slot < 17'(pfla_pkg::SLOTS))
                begin
                    we = 1'b1;
                    used_req.add = 1'b1;
                    used_req.amount = 33'(header_reg);
                end
            end
            S_A_FIN:
            begin
                we = 1'b1;
                wr_next_en = 1'b0;
                w_class = idx_reg[CLS_W-1:0];
                used_req.add = 1'b1;
                used_req.amount = 33'(sz_reg) - 33'(header_reg);
            end
            S_F_PUSH:
            begin
                we = 1'b1;
                w_class = cls_reg;
                w_next = head_reg[cls_reg];
                used_req.sub = 1'b1;
                used_req.amount = sh_out[32:0] - 33'(header_reg);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    pfla_used u_used
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (used_req),
        .used_bytes (used_bytes)
    );

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign address     = (status_reg == pfla_pkg::ST_DONE) ? addr_reg : 16'd0;
    assign class_count = 5'(active_reg);

    // A result strobe only follows the reply step.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_REPLY)
        else $error("result strobe without reply step");

    // The class count never exceeds the number of size classes.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= CNT_W'(pfla_pkg::MAX_CLASSES))
        else $error("class count out of range");

    // Add and subtract are never requested together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(used_req.add && used_req.sub))
        else $error("conflicting used-counter requests");

endmodule
